>>> design/spdp_pkg.sv
// ----------------------------------------------------------------------------
// spdp_pkg
// Types, widths and reset values shared by the scaled pixel packer.
// ----------------------------------------------------------------------------
`default_nettype none

package spdp_pkg;

    // Largest image dimension; coordinate and size fields follow from it.
    localparam int MAX_DIM          = 4096;
    localparam int COORD_W          = $clog2(MAX_DIM);
    localparam int DIM_W            = COORD_W + 1;
    localparam int PROD_W           = COORD_W + DIM_W;
    localparam int SRC_W            = PROD_W + 1;

    localparam int IMAGE_PIXELS_DEF = 65536;
    localparam int IDX_W            = 16;
    localparam int CHAN_W           = 8;
    localparam int PIXEL_W          = 3 * CHAN_W;
    localparam int BRIGHT_W         = 9;
    localparam int FULL_BRIGHT      = 256;
    localparam int OFF_W            = 5;
    localparam int LEN_W            = 4;
    localparam int CFMT_W           = OFF_W + LEN_W;
    localparam int FMT_W            = 3 * CFMT_W;
    localparam int OUT_W            = 32;

    // APB register file: eight 32-bit registers at byte addresses 4*i.
    localparam int APB_DATA_W       = 32;
    localparam int APB_ADDR_W       = 5;

    localparam logic [DIM_W-1:0]   RST_IMAGE_WIDTH    = DIM_W'(256);
    localparam logic [COORD_W-1:0] RST_CROP_LEFT      = '0;
    localparam logic [COORD_W-1:0] RST_CROP_TOP       = '0;
    localparam logic [DIM_W-1:0]   RST_CROP_WIDTH     = DIM_W'(256);
    localparam logic [DIM_W-1:0]   RST_CROP_HEIGHT    = DIM_W'(256);
    localparam logic [DIM_W-1:0]   RST_OUT_WIDTH      = DIM_W'(256);
    localparam logic [DIM_W-1:0]   RST_OUT_HEIGHT     = DIM_W'(256);
    localparam logic [FMT_W-1:0]   RST_CHANNEL_FORMAT = FMT_W'(67244304);

    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH    = 3'd0,
        REG_CROP_LEFT      = 3'd1,
        REG_CROP_TOP       = 3'd2,
        REG_CROP_WIDTH     = 3'd3,
        REG_CROP_HEIGHT    = 3'd4,
        REG_OUT_WIDTH      = 3'd5,
        REG_OUT_HEIGHT     = 3'd6,
        REG_CHANNEL_FORMAT = 3'd7
    } t_reg_idx;

    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_DRAW = 1'b1
    } t_mode;

    typedef struct packed {
        logic [DIM_W-1:0]   image_width;
        logic [COORD_W-1:0] crop_left;
        logic [COORD_W-1:0] crop_top;
        logic [DIM_W-1:0]   crop_width;
        logic [DIM_W-1:0]   crop_height;
        logic [DIM_W-1:0]   out_width;
        logic [DIM_W-1:0]   out_height;
        logic [FMT_W-1:0]   channel_format;
    } t_cfg;

    typedef struct packed {
        logic                mode;
        logic [IDX_W-1:0]    pixel_index;
        logic [CHAN_W-1:0]   load_red;
        logic [CHAN_W-1:0]   load_green;
        logic [CHAN_W-1:0]   load_blue;
        logic [COORD_W-1:0]  dest_col;
        logic [COORD_W-1:0]  dest_row;
        logic [BRIGHT_W-1:0] brightness;
    } t_in_item;

    typedef struct packed {
        logic [OUT_W-1:0] packed_pixel;
        logic             pixel_valid;
    } t_out_item;

    // What an item carries alongside the coordinate arithmetic.
    typedef struct packed {
        logic                mode;
        logic [IDX_W-1:0]    pixel_index;
        logic [PIXEL_W-1:0]  rgb;
        logic [BRIGHT_W-1:0] brightness;
    } t_side;

endpackage

`default_nettype wire

>>> design/spdp_if.sv
// ----------------------------------------------------------------------------
// spdp_in_if / spdp_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface spdp_in_if;
    import spdp_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface spdp_out_if;
    import spdp_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/spdp_cfg.sv
// ----------------------------------------------------------------------------
// spdp_cfg
// APB register file holding the scaling window and channel layout.
// ----------------------------------------------------------------------------
`default_nettype none

module spdp_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [spdp_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [spdp_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [spdp_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    output spdp_pkg::t_cfg                       o_cfg
);
    import spdp_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                REG_IMAGE_WIDTH:    n_cfg.image_width    = pwdata[DIM_W-1:0];
                REG_CROP_LEFT:      n_cfg.crop_left      = pwdata[COORD_W-1:0];
                REG_CROP_TOP:       n_cfg.crop_top       = pwdata[COORD_W-1:0];
                REG_CROP_WIDTH:     n_cfg.crop_width     = pwdata[DIM_W-1:0];
                REG_CROP_HEIGHT:    n_cfg.crop_height    = pwdata[DIM_W-1:0];
                REG_OUT_WIDTH:      n_cfg.out_width      = pwdata[DIM_W-1:0];
                REG_OUT_HEIGHT:     n_cfg.out_height     = pwdata[DIM_W-1:0];
                REG_CHANNEL_FORMAT: n_cfg.channel_format = pwdata[FMT_W-1:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_IMAGE_WIDTH:    prdata = APB_DATA_W'(r_cfg.image_width);
            REG_CROP_LEFT:      prdata = APB_DATA_W'(r_cfg.crop_left);
            REG_CROP_TOP:       prdata = APB_DATA_W'(r_cfg.crop_top);
            REG_CROP_WIDTH:     prdata = APB_DATA_W'(r_cfg.crop_width);
            REG_CROP_HEIGHT:    prdata = APB_DATA_W'(r_cfg.crop_height);
            REG_OUT_WIDTH:      prdata = APB_DATA_W'(r_cfg.out_width);
            REG_OUT_HEIGHT:     prdata = APB_DATA_W'(r_cfg.out_height);
            REG_CHANNEL_FORMAT: prdata = APB_DATA_W'(r_cfg.channel_format);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width    <= RST_IMAGE_WIDTH;
            r_cfg.crop_left      <= RST_CROP_LEFT;
            r_cfg.crop_top       <= RST_CROP_TOP;
            r_cfg.crop_width     <= RST_CROP_WIDTH;
            r_cfg.crop_height    <= RST_CROP_HEIGHT;
            r_cfg.out_width      <= RST_OUT_WIDTH;
            r_cfg.out_height     <= RST_OUT_HEIGHT;
            r_cfg.channel_format <= RST_CHANNEL_FORMAT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> design/spdp_div.sv
// ----------------------------------------------------------------------------
// spdp_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module spdp_div #(
    parameter int DIVIDEND_W = 25,
    parameter int DIVISOR_W  = 13
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic [DIVIDEND_W-1:0] i_dividend,
    input  wire logic [DIVISOR_W-1:0]  i_divisor,
    output logic      [DIVIDEND_W-1:0] o_quotient
);
    // The divisor comes from a register that the user must change only while
    // the pipeline is empty (not enforced here); it is not carried with the item.
    logic [DIVISOR_W-1:0]  r_rem [DIVIDEND_W];
    logic [DIVIDEND_W-1:0] r_num [DIVIDEND_W-1];
    logic [DIVIDEND_W-1:0] r_quo [DIVIDEND_W];

    for (genvar k = 0; k < DIVIDEND_W; k++) begin : g_stage
        logic [DIVISOR_W-1:0]  rem_in;
        logic [DIVIDEND_W-1:0] num_in;
        logic [DIVIDEND_W-1:0] quo_in;
        logic [DIVISOR_W:0]    trial;
        logic [DIVISOR_W:0]    diff;
        logic                  fits;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign num_in = i_dividend;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign num_in = r_num[k-1];
            assign quo_in = r_quo[k-1];
        end

        assign trial = {rem_in, num_in[DIVIDEND_W-1]};
        assign diff  = trial - {1'b0, i_divisor};
        assign fits  = trial >= {1'b0, i_divisor};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
                r_quo[k] <= {quo_in[DIVIDEND_W-2:0], fits};
            end
        end

        if (k < DIVIDEND_W - 1) begin : g_num
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_num[k] <= {num_in[DIVIDEND_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_quotient = r_quo[DIVIDEND_W-1];

endmodule

`default_nettype wire

>>> design/spdp_store.sv
// ----------------------------------------------------------------------------
// spdp_store
// Single-port image memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spdp_store #(
    parameter int ADDR_W = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_en,
    input  wire logic                             i_we,
    input  wire logic                             i_re,
    input  wire logic [ADDR_W-1:0]                i_addr,
    input  wire logic [spdp_pkg::PIXEL_W-1:0]     i_wdata,
    output logic      [spdp_pkg::PIXEL_W-1:0]     o_rdata
);
    import spdp_pkg::*;

    localparam int DEPTH = 2 ** ADDR_W;

    logic [PIXEL_W-1:0] r_mem [DEPTH];
    logic [PIXEL_W-1:0] r_rdata;

    // The read register holds while the pipeline is stalled.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end
            if (i_re) begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> design/spdp_pack.sv
// ----------------------------------------------------------------------------
// spdp_pack
// Brightness scaling of the three channels and packing into one word.
// ----------------------------------------------------------------------------
`default_nettype none

module spdp_pack (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [spdp_pkg::PIXEL_W-1:0]  i_rgb,
    input  wire logic [spdp_pkg::BRIGHT_W-1:0] i_brightness,
    input  wire logic [spdp_pkg::FMT_W-1:0]    i_fmt,
    output logic      [spdp_pkg::OUT_W-1:0]    o_packed
);
    import spdp_pkg::*;

    localparam int DIM_PROD_W = CHAN_W + BRIGHT_W;

    function automatic logic [OUT_W-1:0] place_chan(
        input logic [CHAN_W-1:0] c,
        input logic [CFMT_W-1:0] fmt
    );
        logic [OFF_W-1:0]  off;
        logic [LEN_W-1:0]  len;
        logic [LEN_W-1:0]  sh;
        logic [CHAN_W-1:0] cs;
        off = fmt[OFF_W-1:0];
        len = fmt[CFMT_W-1:OFF_W];
        if (len > LEN_W'(CHAN_W)) begin
            len = LEN_W'(CHAN_W);
        end
        sh = LEN_W'(CHAN_W) - len;
        cs = c >> sh;
        // Bits shifted past the top of the word are dropped.
        return (len == '0) ? '0 : (OUT_W'(cs) << off);
    endfunction

    logic [BRIGHT_W-1:0]   w_br;
    logic [DIM_PROD_W-1:0] w_pr, w_pg, w_pb;
    logic [CHAN_W-1:0]     r_r, r_g, r_b;

    assign w_br = (i_brightness > BRIGHT_W'(FULL_BRIGHT)) ? BRIGHT_W'(FULL_BRIGHT)
                                                          : i_brightness;
    assign w_pr = DIM_PROD_W'(i_rgb[3*CHAN_W-1:2*CHAN_W]) * DIM_PROD_W'(w_br);
    assign w_pg = DIM_PROD_W'(i_rgb[2*CHAN_W-1:CHAN_W]) * DIM_PROD_W'(w_br);
    assign w_pb = DIM_PROD_W'(i_rgb[CHAN_W-1:0]) * DIM_PROD_W'(w_br);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r <= w_pr[2*CHAN_W-1:CHAN_W];
            r_g <= w_pg[2*CHAN_W-1:CHAN_W];
            r_b <= w_pb[2*CHAN_W-1:CHAN_W];
        end
    end

    assign o_packed = place_chan(r_r, i_fmt[CFMT_W-1:0])
                    | place_chan(r_g, i_fmt[2*CFMT_W-1:CFMT_W])
                    | place_chan(r_b, i_fmt[3*CFMT_W-1:2*CFMT_W]);

endmodule

`default_nettype wire

>>> design/scaled_pixel_dim_pack.sv
// ----------------------------------------------------------------------------
// scaled_pixel_dim_pack
// Nearest-neighbor image scaler with brightness and configurable packing.
// ----------------------------------------------------------------------------
// The block takes one item per clock while the output is not held back and
// returns one result per item, in order. Most of the pipeline is the pair of
// 25-stage pipelined dividers that map the destination column and row onto
// the source window; after them come the crop offset, the address multiply,
// one access to the single-port image memory, the brightness multiply and
// the packing. Loads write the memory at the same pipeline stage where draws
// read it, so every draw sees exactly the loads accepted before it. A stalled
// output freezes the whole pipeline. IMAGE_PIXELS must be a power of two;
// store addresses wrap at that size. Configuration must be written over APB
// only while no item is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module scaled_pixel_dim_pack #(
    parameter int IMAGE_PIXELS = spdp_pkg::IMAGE_PIXELS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    spdp_in_if.sink                              i_pix,
    spdp_out_if.source                           o_pix,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [spdp_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [spdp_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [spdp_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready
);
    import spdp_pkg::*;

    localparam int ADDR_W   = $clog2(IMAGE_PIXELS);
    localparam int DIV_LAT  = PROD_W;
    localparam int MULT_W   = ADDR_W + DIM_W;

    t_cfg w_cfg;
    logic adv;

    // Stage A: accepted item.
    logic     r_a_vld;
    t_in_item r_a_item;
    t_side    n_a_side;

    // Stage B: scaled products into the dividers.
    logic              r_b_vld;
    t_side             r_b_side;
    logic [PROD_W-1:0] r_b_px, r_b_py;

    // Divider stages: side line kept in step with the quotients.
    logic [DIV_LAT-1:0] r_q_vld;
    t_side              r_q_side [DIV_LAT];
    logic [DIM_W-1:0]   w_div_x, w_div_y;
    logic [PROD_W-1:0]  w_qx, w_qy;

    // Stage C: source coordinates.
    logic             r_c_vld;
    t_side            r_c_side;
    logic [SRC_W-1:0] r_c_sx, r_c_sy;

    // Stage D: store address.
    logic              r_d_vld;
    t_side             r_d_side;
    logic [ADDR_W-1:0] r_d_addr;
    logic [MULT_W-1:0] n_prod;
    logic [ADDR_W-1:0] n_addr;

    // Stage E: memory access; stage F: dimmed channels.
    logic                r_e_vld;
    logic                r_e_mode;
    logic [BRIGHT_W-1:0] r_e_bright;
    logic [PIXEL_W-1:0]  w_rdata;
    logic                w_we, w_re;
    logic                r_f_vld;
    logic                r_f_mode;
    logic [OUT_W-1:0]    w_packed;

    logic      r_out_vld;
    t_out_item r_out;

    spdp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign adv         = !r_out_vld || o_pix.ready;
    assign i_pix.ready = adv;

    assign n_a_side.mode        = r_a_item.mode;
    assign n_a_side.pixel_index = r_a_item.pixel_index;
    assign n_a_side.rgb         = {r_a_item.load_red, r_a_item.load_green,
                                   r_a_item.load_blue};
    assign n_a_side.brightness  = r_a_item.brightness;

    // A zero output size divides as one.
    assign w_div_x = (w_cfg.out_width == '0) ? DIM_W'(1) : w_cfg.out_width;
    assign w_div_y = (w_cfg.out_height == '0) ? DIM_W'(1) : w_cfg.out_height;

    spdp_div #(.DIVIDEND_W(PROD_W), .DIVISOR_W(DIM_W)) u_div_x (
        .i_clk      (i_clk),
        .i_en       (adv),
        .i_dividend (r_b_px),
        .i_divisor  (w_div_x),
        .o_quotient (w_qx)
    );

    spdp_div #(.DIVIDEND_W(PROD_W), .DIVISOR_W(DIM_W)) u_div_y (
        .i_clk      (i_clk),
        .i_en       (adv),
        .i_dividend (r_b_py),
        .i_divisor  (w_div_y),
        .o_quotient (w_qy)
    );

    assign n_prod = MULT_W'(ADDR_W'(r_c_sy)) * MULT_W'(w_cfg.image_width);
    assign n_addr = (r_c_side.mode == MODE_DRAW)
                  ? ADDR_W'(n_prod) + ADDR_W'(r_c_sx)
                  : ADDR_W'(r_c_side.pixel_index);

    assign w_we = r_d_vld && (r_d_side.mode == MODE_LOAD);
    assign w_re = r_d_vld && (r_d_side.mode == MODE_DRAW);

    spdp_store #(.ADDR_W(ADDR_W)) u_store (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_we    (w_we),
        .i_re    (w_re),
        .i_addr  (r_d_addr),
        .i_wdata (r_d_side.rgb),
        .o_rdata (w_rdata)
    );

    spdp_pack u_pack (
        .i_clk        (i_clk),
        .i_en         (adv),
        .i_rgb        (w_rdata),
        .i_brightness (r_e_bright),
        .i_fmt        (w_cfg.channel_format),
        .o_packed     (w_packed)
    );

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_q_vld   <= '0;
            r_c_vld   <= 1'b0;
            r_d_vld   <= 1'b0;
            r_e_vld   <= 1'b0;
            r_f_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_a_vld   <= i_pix.valid;
            r_b_vld   <= r_a_vld;
            r_q_vld   <= {r_q_vld[DIV_LAT-2:0], r_b_vld};
            r_c_vld   <= r_q_vld[DIV_LAT-1];
            r_d_vld   <= r_c_vld;
            r_e_vld   <= r_d_vld;
            r_f_vld   <= r_e_vld;
            r_out_vld <= r_f_vld;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_item    <= i_pix.data;
            r_b_side    <= n_a_side;
            r_b_px      <= PROD_W'(r_a_item.dest_col) * PROD_W'(w_cfg.crop_width);
            r_b_py      <= PROD_W'(r_a_item.dest_row) * PROD_W'(w_cfg.crop_height);
            r_q_side[0] <= r_b_side;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_q_side[k] <= r_q_side[k-1];
            end
            r_c_side   <= r_q_side[DIV_LAT-1];
            r_c_sx     <= SRC_W'(w_cfg.crop_left) + SRC_W'(w_qx);
            r_c_sy     <= SRC_W'(w_cfg.crop_top) + SRC_W'(w_qy);
            r_d_side   <= r_c_side;
            r_d_addr   <= n_addr;
            r_e_mode   <= r_d_side.mode;
            r_e_bright <= r_d_side.brightness;
            r_f_mode   <= r_e_mode;
            r_out.packed_pixel <= (r_f_mode == MODE_DRAW) ? w_packed : '0;
            r_out.pixel_valid  <= r_f_mode;
        end
    end

    assign o_pix.valid = r_out_vld;
    assign o_pix.data  = r_out;

    a_stall_keeps_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> r_out_vld)
        else $error("pipeline stalled without a pending result");

    a_port_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_we && w_re))
        else $error("store written and read in the same cycle");

    a_load_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out.pixel_valid) |-> (r_out.packed_pixel == '0))
        else $error("load acknowledge carries pixel data");

    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_div_x != '0) && (w_div_y != '0))
        else $error("zero divisor reached the divider");

    a_accept_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> r_a_vld)
        else $error("accepted item not captured");

endmodule

`default_nettype wire
